>>> rtl/core/wvs_pkg.sv
// Package for the weighted vertex skinning block: widths, controller
// command struct and shared helper functions. No dependencies.
package wvs_pkg;

    localparam int POS_W  = 32;
    localparam int QUAT_W = 16;
    localparam int BIAS_W = 17;
    // Widths of intermediate products
    localparam int T_W    = 36;   // first product, rounded to Q.16
    localparam int R_W    = 38;   // second product, rounded to Q.16
    localparam int S_W    = 39;   // joint position + rotated weight
    localparam int C_W    = 40;   // contribution after bias scaling

    // Step codes for the datapath sequencer
    localparam logic [2:0] STEP_T  = 3'd0;  // first quaternion product
    localparam logic [2:0] STEP_R  = 3'd1;  // second quaternion product
    localparam logic [2:0] STEP_S  = 3'd2;  // add joint position
    localparam logic [2:0] STEP_C  = 3'd3;  // bias scaling
    localparam logic [2:0] STEP_A  = 3'd4;  // accumulate

    typedef struct packed {
        logic       load;      // capture input transaction
        logic       step_en;   // run one datapath step
        logic [2:0] step;      // which step
        logic       emit;      // copy accumulator plus last contribution to output register, clear it
    } wvs_cmd_t;

    // Saturate a 41 bit signed value to 32 bits
    function automatic logic signed [POS_W-1:0] sat32(input logic signed [C_W:0] v);
        logic signed [C_W:0] max_v;
        logic signed [C_W:0] min_v;
        max_v = (C_W+1)'(64'sh7FFFFFFF);
        min_v = -max_v - (C_W+1)'(1);
        if (v > max_v)
            sat32 = 32'sh7FFFFFFF;
        else if (v < min_v)
            sat32 = 32'sh80000000;
        else
            sat32 = v[POS_W-1:0];
    endfunction

endpackage

>>> rtl/core/wvs_datapath.sv
// Datapath of the skinning block: input registers, quaternion products,
// bias scaling, saturating accumulator and output register. Uses wvs_pkg.
module wvs_datapath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  wvs_pkg::wvs_cmd_t                      cmd,
    input  logic signed [wvs_pkg::POS_W-1:0]       joint_pos_x,
    input  logic signed [wvs_pkg::POS_W-1:0]       joint_pos_y,
    input  logic signed [wvs_pkg::POS_W-1:0]       joint_pos_z,
    input  logic signed [wvs_pkg::QUAT_W-1:0]      quat_w,
    input  logic signed [wvs_pkg::QUAT_W-1:0]      quat_x,
    input  logic signed [wvs_pkg::QUAT_W-1:0]      quat_y,
    input  logic signed [wvs_pkg::QUAT_W-1:0]      quat_z,
    input  logic signed [wvs_pkg::POS_W-1:0]       weight_pos_x,
    input  logic signed [wvs_pkg::POS_W-1:0]       weight_pos_y,
    input  logic signed [wvs_pkg::POS_W-1:0]       weight_pos_z,
    input  logic        [wvs_pkg::BIAS_W-1:0]      bias,
    output logic signed [wvs_pkg::POS_W-1:0]       vertex_x,
    output logic signed [wvs_pkg::POS_W-1:0]       vertex_y,
    output logic signed [wvs_pkg::POS_W-1:0]       vertex_z
);

    // captured transaction
    logic signed [wvs_pkg::POS_W-1:0]  jx_reg, jy_reg, jz_reg;
    logic signed [wvs_pkg::POS_W-1:0]  px_reg, py_reg, pz_reg;
    logic signed [wvs_pkg::QUAT_W-1:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic        [wvs_pkg::BIAS_W-1:0] b_reg;
    // intermediates
    logic signed [wvs_pkg::T_W-1:0]    tw_reg, tx_reg, ty_reg, tz_reg;
    logic signed [wvs_pkg::R_W-1:0]    rx_reg, ry_reg, rz_reg;
    logic signed [wvs_pkg::S_W-1:0]    sx_reg, sy_reg, sz_reg;
    logic signed [wvs_pkg::POS_W-1:0]  cx_reg, cy_reg, cz_reg;
    logic signed [wvs_pkg::POS_W-1:0]  ax_reg, ay_reg, az_reg;
    logic signed [wvs_pkg::POS_W-1:0]  vx_reg, vy_reg, vz_reg;

    logic signed [wvs_pkg::T_W-1:0]    tw_next, tx_next, ty_next, tz_next;
    logic signed [wvs_pkg::R_W-1:0]    rx_next, ry_next, rz_next;
    logic signed [wvs_pkg::POS_W-1:0]  cx_next, cy_next, cz_next;
    logic signed [wvs_pkg::POS_W-1:0]  ax_next, ay_next, az_next;

    // Round Q.30 sum to Q.16, half up
    function automatic logic signed [55:0] rnd14(input logic signed [55:0] v);
        rnd14 = (v + 56'sd8192) >>> 14;
    endfunction

    // Bias scaling of one axis: (s * b + 2^15) >> 16, saturated
    function automatic logic signed [wvs_pkg::POS_W-1:0] scale(
        input logic signed [wvs_pkg::S_W-1:0]  s,
        input logic        [wvs_pkg::BIAS_W-1:0] b);
        logic signed [56:0] p;
        logic signed [56:0] q;
        p = 57'(s) * $signed({1'b0, b});
        q = (p + 57'sd32768) >>> 16;
        scale = wvs_pkg::sat32(q[wvs_pkg::C_W:0]);
    endfunction

    // first quaternion product, t = q * (0, p)
    always_comb
    begin
        logic signed [55:0] a, b, c, d;
        a = -(56'(qx_reg) * 56'(px_reg)) - 56'(qy_reg) * 56'(py_reg)
            - 56'(qz_reg) * 56'(pz_reg);
        b = 56'(qw_reg) * 56'(px_reg) + 56'(qy_reg) * 56'(pz_reg)
            - 56'(qz_reg) * 56'(py_reg);
        c = 56'(qw_reg) * 56'(py_reg) + 56'(qz_reg) * 56'(px_reg)
            - 56'(qx_reg) * 56'(pz_reg);
        d = 56'(qw_reg) * 56'(pz_reg) + 56'(qx_reg) * 56'(py_reg)
            - 56'(qy_reg) * 56'(px_reg);
        a = rnd14(a);
        b = rnd14(b);
        c = rnd14(c);
        d = rnd14(d);
        tw_next = a[wvs_pkg::T_W-1:0];
        tx_next = b[wvs_pkg::T_W-1:0];
        ty_next = c[wvs_pkg::T_W-1:0];
        tz_next = d[wvs_pkg::T_W-1:0];
    end

    // second quaternion product, r = t * conj(q)
    always_comb
    begin
        logic signed [55:0] a, b, c;
        a = 56'(tx_reg) * 56'(qw_reg) - 56'(tw_reg) * 56'(qx_reg)
            - 56'(ty_reg) * 56'(qz_reg) + 56'(tz_reg) * 56'(qy_reg);
        b = 56'(ty_reg) * 56'(qw_reg) - 56'(tw_reg) * 56'(qy_reg)
            - 56'(tz_reg) * 56'(qx_reg) + 56'(tx_reg) * 56'(qz_reg);
        c = 56'(tz_reg) * 56'(qw_reg) - 56'(tw_reg) * 56'(qz_reg)
            - 56'(tx_reg) * 56'(qy_reg) + 56'(ty_reg) * 56'(qx_reg);
        a = rnd14(a);
        b = rnd14(b);
        c = rnd14(c);
        rx_next = a[wvs_pkg::R_W-1:0];
        ry_next = b[wvs_pkg::R_W-1:0];
        rz_next = c[wvs_pkg::R_W-1:0];
    end

    // scaling and saturating accumulation
    always_comb
    begin
        cx_next = scale(sx_reg, b_reg);
        cy_next = scale(sy_reg, b_reg);
        cz_next = scale(sz_reg, b_reg);
        ax_next = wvs_pkg::sat32((wvs_pkg::C_W+1)'(ax_reg) + (wvs_pkg::C_W+1)'(cx_reg));
        ay_next = wvs_pkg::sat32((wvs_pkg::C_W+1)'(ay_reg) + (wvs_pkg::C_W+1)'(cy_reg));
        az_next = wvs_pkg::sat32((wvs_pkg::C_W+1)'(az_reg) + (wvs_pkg::C_W+1)'(cz_reg));
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            jx_reg <= joint_pos_x;  jy_reg <= joint_pos_y;  jz_reg <= joint_pos_z;
            px_reg <= weight_pos_x; py_reg <= weight_pos_y; pz_reg <= weight_pos_z;
            qw_reg <= quat_w; qx_reg <= quat_x; qy_reg <= quat_y; qz_reg <= quat_z;
            b_reg  <= bias;
        end
        if (cmd.step_en)
        begin
            unique case (cmd.step)
                wvs_pkg::STEP_T:
                begin
                    tw_reg <= tw_next; tx_reg <= tx_next;
                    ty_reg <= ty_next; tz_reg <= tz_next;
                end
                wvs_pkg::STEP_R:
                begin
                    rx_reg <= rx_next; ry_reg <= ry_next; rz_reg <= rz_next;
                end
                wvs_pkg::STEP_S:
                begin
                    sx_reg <= wvs_pkg::S_W'(jx_reg) + wvs_pkg::S_W'(rx_reg);
                    sy_reg <= wvs_pkg::S_W'(jy_reg) + wvs_pkg::S_W'(ry_reg);
                    sz_reg <= wvs_pkg::S_W'(jz_reg) + wvs_pkg::S_W'(rz_reg);
                end
                wvs_pkg::STEP_C:
                begin
                    cx_reg <= cx_next; cy_reg <= cy_next; cz_reg <= cz_next;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.emit)
        begin
            vx_reg <= ax_next; vy_reg <= ay_next; vz_reg <= az_next;
        end
    end

    // accumulator, cleared after a vertex is emitted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg <= '0; ay_reg <= '0; az_reg <= '0;
        end
        else if (cmd.emit)
        begin
            ax_reg <= '0; ay_reg <= '0; az_reg <= '0;
        end
        else if (cmd.step_en && cmd.step == wvs_pkg::STEP_A)
        begin
            ax_reg <= ax_next; ay_reg <= ay_next; az_reg <= az_next;
        end
    end

    assign vertex_x = vx_reg;
    assign vertex_y = vy_reg;
    assign vertex_z = vz_reg;

endmodule

>>> rtl/core/wvs_ctrl.sv
// Controller of the skinning block: sequences the datapath steps and
// runs the input/output handshakes. Uses wvs_pkg.
module wvs_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              in_last,
    output logic              out_valid,
    input  logic              out_stall,
    output wvs_pkg::wvs_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_T    = 3'd1;
    localparam logic [2:0] S_R    = 3'd2;
    localparam logic [2:0] S_S    = 3'd3;
    localparam logic [2:0] S_C    = 3'd4;
    localparam logic [2:0] S_A    = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       last_reg, last_next;
    logic       ov_reg, ov_next;
    logic       accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_valid = ov_reg;

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        last_next   = last_reg;
        ov_next     = ov_reg && out_stall;
        cmd.load    = 1'b0;
        cmd.step_en = 1'b0;
        cmd.step    = wvs_pkg::STEP_T;
        cmd.emit    = 1'b0;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    last_next  = in_last;
                    state_next = S_T;
                end
            S_T:
            begin
                cmd.step_en = 1'b1; cmd.step = wvs_pkg::STEP_T; state_next = S_R;
            end
            S_R:
            begin
                cmd.step_en = 1'b1; cmd.step = wvs_pkg::STEP_R; state_next = S_S;
            end
            S_S:
            begin
                cmd.step_en = 1'b1; cmd.step = wvs_pkg::STEP_S; state_next = S_C;
            end
            S_C:
            begin
                cmd.step_en = 1'b1; cmd.step = wvs_pkg::STEP_C;
                state_next = last_reg ? S_EMIT : S_A;
            end
            S_A:
            begin
                cmd.step_en = 1'b1; cmd.step = wvs_pkg::STEP_A; state_next = S_IDLE;
            end
            S_EMIT:
                // wait for the output register to be free
                if (!ov_next)
                begin
                    cmd.emit   = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

>>> rtl/core/weighted_vertex_skinning.sv
// Weighted vertex skinning: one skin weight per input transaction. wvs_ctrl
// loads each weight, runs both quaternion products, the joint add and the
// bias scaling, then accumulates it, or for a vertex's last weight emits the
// vertex once the output register is free; no new weight is taken until then.
// The finished vertex waits in an output register while the next weight runs.
// Top level, joins wvs_ctrl and wvs_datapath; uses wvs_pkg.
module weighted_vertex_skinning
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [wvs_pkg::POS_W-1:0]       joint_pos_x,
    input  logic signed [wvs_pkg::POS_W-1:0]       joint_pos_y,
    input  logic signed [wvs_pkg::POS_W-1:0]       joint_pos_z,
    input  logic signed [wvs_pkg::QUAT_W-1:0]      quat_w,
    input  logic signed [wvs_pkg::QUAT_W-1:0]      quat_x,
    input  logic signed [wvs_pkg::QUAT_W-1:0]      quat_y,
    input  logic signed [wvs_pkg::QUAT_W-1:0]      quat_z,
    input  logic signed [wvs_pkg::POS_W-1:0]       weight_pos_x,
    input  logic signed [wvs_pkg::POS_W-1:0]       weight_pos_y,
    input  logic signed [wvs_pkg::POS_W-1:0]       weight_pos_z,
    input  logic        [wvs_pkg::BIAS_W-1:0]      bias,
    input  logic                                   last_weight,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [wvs_pkg::POS_W-1:0]       vertex_x,
    output logic signed [wvs_pkg::POS_W-1:0]       vertex_y,
    output logic signed [wvs_pkg::POS_W-1:0]       vertex_z
);

    wvs_pkg::wvs_cmd_t cmd;

    wvs_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_last(last_weight), .out_valid(out_valid), .out_stall(out_stall),
        .cmd(cmd)
    );

    wvs_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .joint_pos_x(joint_pos_x), .joint_pos_y(joint_pos_y), .joint_pos_z(joint_pos_z),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .weight_pos_x(weight_pos_x), .weight_pos_y(weight_pos_y),
        .weight_pos_z(weight_pos_z), .bias(bias),
        .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z)
    );

endmodule

>>> rtl/core/wvs_checker.sv
// Port checker for the skinning block and its bind to the top level.
// Sees only the top level's ports.
module wvs_port_assert
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        last_weight,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] vertex_x
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(vertex_x))
        else $error("stalled vertex changed");

    // after an accepted transaction the block is busy for the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken in consecutive cycles");

    // a non-last weight never raises a result
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !last_weight && !out_valid |=> !out_valid)
        else $error("result without last weight");

endmodule

bind weighted_vertex_skinning wvs_port_assert u_wvs_checker
(
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .last_weight(last_weight), .out_valid(out_valid), .out_stall(out_stall),
    .vertex_x(vertex_x)
);

>>> test/wvs_checker.sv
// Checker for weighted_vertex_skinning: watches both channels, predicts each
// skinned vertex and compares it with what the block emits. Uses wvs_pkg.
`timescale 1ns / 1ps
module wvs_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic signed [wvs_pkg::POS_W-1:0]     joint_pos_x,
    input  logic signed [wvs_pkg::POS_W-1:0]     joint_pos_y,
    input  logic signed [wvs_pkg::POS_W-1:0]     joint_pos_z,
    input  logic signed [wvs_pkg::QUAT_W-1:0]    quat_w,
    input  logic signed [wvs_pkg::QUAT_W-1:0]    quat_x,
    input  logic signed [wvs_pkg::QUAT_W-1:0]    quat_y,
    input  logic signed [wvs_pkg::QUAT_W-1:0]    quat_z,
    input  logic signed [wvs_pkg::POS_W-1:0]     weight_pos_x,
    input  logic signed [wvs_pkg::POS_W-1:0]     weight_pos_y,
    input  logic signed [wvs_pkg::POS_W-1:0]     weight_pos_z,
    input  logic        [wvs_pkg::BIAS_W-1:0]    bias,
    input  logic                                 last_weight,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic signed [wvs_pkg::POS_W-1:0]     vertex_x,
    input  logic signed [wvs_pkg::POS_W-1:0]     vertex_y,
    input  logic signed [wvs_pkg::POS_W-1:0]     vertex_z,
    output int                                   errors,
    output int                                   pending,
    output int                                   vertices_seen
);

    typedef struct packed {
        logic signed [wvs_pkg::POS_W-1:0] x;
        logic signed [wvs_pkg::POS_W-1:0] y;
        logic signed [wvs_pkg::POS_W-1:0] z;
    } vertex_t;

    vertex_t expected_vertices[$];
    longint  acc_x, acc_y, acc_z;

    // round half up: add half an LSB, then floor shift
    function automatic longint round_shift(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // rotate weight by q * p * conj(q), add joint, scale by bias, accumulate
    task automatic skin_weight();
        longint jx, jy, jz, qw, qx, qy, qz, px, py, pz, b;
        longint tw, tx, ty, tz, rx, ry, rz;
        vertex_t v;
        jx = joint_pos_x;  jy = joint_pos_y;  jz = joint_pos_z;
        qw = quat_w;  qx = quat_x;  qy = quat_y;  qz = quat_z;
        px = weight_pos_x;  py = weight_pos_y;  pz = weight_pos_z;
        b = longint'(bias);
        tw = round_shift(-(qx * px) - (qy * py) - (qz * pz), 14);
        tx = round_shift((qw * px) + (qy * pz) - (qz * py), 14);
        ty = round_shift((qw * py) + (qz * px) - (qx * pz), 14);
        tz = round_shift((qw * pz) + (qx * py) - (qy * px), 14);
        rx = round_shift(tx * qw - tw * qx - ty * qz + tz * qy, 14);
        ry = round_shift(ty * qw - tw * qy - tz * qx + tx * qz, 14);
        rz = round_shift(tz * qw - tw * qz - tx * qy + ty * qx, 14);
        acc_x = clamp32(acc_x + clamp32(round_shift((jx + rx) * b, 16)));
        acc_y = clamp32(acc_y + clamp32(round_shift((jy + ry) * b, 16)));
        acc_z = clamp32(acc_z + clamp32(round_shift((jz + rz) * b, 16)));
        if (last_weight)
        begin
            v.x = acc_x[31:0];
            v.y = acc_y[31:0];
            v.z = acc_z[31:0];
            expected_vertices.push_back(v);
            acc_x = 0;
            acc_y = 0;
            acc_z = 0;
        end
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
        vertices_seen = 0;
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
    end

    // sample both channels at the edge, before the block's own updates land
    always @(posedge clk)
    begin
        vertex_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                vertices_seen++;
                if (expected_vertices.size() == 0)
                begin
                    report("unexpected vertex x", vertex_x, 0);
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    if (vertex_x !== want.x) report("vertex_x", vertex_x, want.x);
                    if (vertex_y !== want.y) report("vertex_y", vertex_y, want.y);
                    if (vertex_z !== want.z) report("vertex_z", vertex_z, want.z);
                end
            end
            if (in_valid && !in_stall)
                skin_weight();
            pending = expected_vertices.size();
        end
    end

endmodule

>>> test/tb_weighted_vertex_skinning.sv
// Testbench top for weighted_vertex_skinning: drives weight transactions and
// output stalls, and gives the verdict. Depends on wvs_pkg and wvs_checker.
`timescale 1ns / 1ps
module tb_weighted_vertex_skinning;

    localparam int CYCLE_LIMIT = 600000;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic signed [wvs_pkg::POS_W-1:0]  joint_pos_x = '0, joint_pos_y = '0, joint_pos_z = '0;
    logic signed [wvs_pkg::QUAT_W-1:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
    logic signed [wvs_pkg::POS_W-1:0]  weight_pos_x = '0, weight_pos_y = '0;
    logic signed [wvs_pkg::POS_W-1:0]  weight_pos_z = '0;
    logic        [wvs_pkg::BIAS_W-1:0] bias = '0;
    logic                              last_weight = 1'b0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [wvs_pkg::POS_W-1:0]  vertex_x, vertex_y, vertex_z;

    int errors, pending, vertices_seen;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;
    int weights_sent = 0;

    weighted_vertex_skinning i_dut (.*);

    wvs_checker i_checker (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // random output back-pressure
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("weighted_vertex_skinning verification failed");
            $finish;
        end
    end

    // present one weight and hold it until accepted
    task automatic send_weight(input logic [31:0] jx, jy, jz,
                               input logic [15:0] qw, qx, qy, qz,
                               input logic [31:0] px, py, pz,
                               input logic [16:0] b, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        joint_pos_x <= jx;  joint_pos_y <= jy;  joint_pos_z <= jz;
        quat_w <= qw;  quat_x <= qx;  quat_y <= qy;  quat_z <= qz;
        weight_pos_x <= px;  weight_pos_y <= py;  weight_pos_z <= pz;
        bias <= b;
        last_weight <= lst;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        weights_sent++;
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'(int'($urandom_range(2 * 65536 * 64)) - 65536 * 64);
            2: return 32'(int'($urandom_range(2 * 65536 * 4096)) - 65536 * 4096);
            default: return ($urandom_range(1) != 0) ? 32'h7FFFFFFF : 32'h80000000;
        endcase
    endfunction

    function automatic logic [15:0] rand_quat();
        return 16'(int'($urandom_range(32768)) - 16384);
    endfunction

    function automatic logic [16:0] rand_bias();
        case ($urandom_range(3))
            0: return 17'd65536;
            1: return 17'($urandom_range(65536));
            default: return 17'($urandom_range(32768));
        endcase
    endfunction

    task automatic random_vertices(input int n_weights);
        int left;
        int count;
        count = 0;
        while (count < n_weights)
        begin
            left = $urandom_range(1, 4);
            repeat (left)
            begin
                left--;
                // mostly well-formed vertices, sometimes a stray flag
                send_weight(rand_pos(), rand_pos(), rand_pos(),
                            rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                            rand_pos(), rand_pos(), rand_pos(), rand_bias(),
                            ($urandom_range(19) == 0) ? 1'b1 : (left == 0));
                count++;
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, extremes, non-unit quaternions, saturation
        send_idle_pct = 15;
        recv_stall_pct = 57;
        send_weight(32'h00010000, 32'hFFFF0000, 32'h0, 16'sd16384, '0, '0, '0,
                    32'h00020000, 32'h00030000, 32'hFFFC0000, 17'd65536, 1'b1);
        send_weight(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                    16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
                    32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 17'd65536, 1'b1);
        send_weight(32'h80000000, 32'h80000000, 32'h80000000,
                    -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384,
                    32'h80000000, 32'h80000000, 32'h80000000, 17'd65536, 1'b1);
        send_weight(32'h7FFFFFFF, 32'h80000000, 32'h12345678,
                    '0, -16'sd16384, 16'sd16384, '0,
                    32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 17'd0, 1'b1);
        // saturating accumulation over several weights
        repeat (4)
            send_weight(32'h7FFFFFFF, 32'h80000000, 32'h40000000, 16'sd16384, '0, '0, '0,
                        32'h7FFFFFFF, 32'h80000000, 32'h40000000, 17'd65536, 1'b0);
        send_weight('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 17'd1, 1'b1);
        // biases not summing to one, non-unit quaternion
        send_weight(32'h00050000, 32'h00010000, 32'hFFFE0000, 16'sd8000, 16'sd3000,
                    -16'sd2000, 16'sd100, 32'h00010000, 32'h00020000, 32'h00030000,
                    17'd20000, 1'b0);
        send_weight(32'hFFFB0000, 32'h00070000, 32'h00010000, 16'sd11585, '0,
                    16'sd11585, '0, 32'h00040000, 32'hFFFF8000, 32'h00008000,
                    17'd30000, 1'b1);
        send_weight(32'hFFFFFFFF, 32'h00000001, 32'h55555555, 16'h5555, 16'hAAAA,
                    16'h3FFF, 16'hC001, 32'hAAAAAAAA, 32'h55555555, 32'h00000001,
                    17'h1FFFF & 17'd65535, 1'b1);

        // let every vertex drain before streaming on
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        random_vertices(570);
        send_idle_pct = 57;
        recv_stall_pct = 15;
        random_vertices(570);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_vertices(570);
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("Run covered %0d weights and %0d vertices under three idle/stall mixes,",
                 weights_sent, vertices_seen);
        $display("with extreme fields, non-unit quaternions and saturating sums.");
        if (errors == 0)
            $display("weighted_vertex_skinning verification clean");
        else
            $display("weighted_vertex_skinning verification failed");
        $finish;
    end

endmodule
